@@ sv/scl_pkg.sv @@
package scl_pkg;

    localparam int unsigned KW_COUNT = 11;

    localparam logic [4:0] LINE_MAX  = 5'd30;
    localparam logic [4:0] FIELD_MAX = 5'd28;

    localparam logic [7:0] CHAR_OPEN  = 8'h43;  // 'C'
    localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CHAR_CR    = 8'h0D;  // carriage return

    localparam logic [31:0] TEAM_CODE_RESET = 32'h3230_3332;

    localparam logic [3:0] CODE_NONE = 4'd0;

    localparam logic [2:0] FIELD_TEAM    = 3'd1;
    localparam logic [2:0] FIELD_KEYWORD = 3'd2;
    localparam logic [2:0] FIELD_LAST    = 3'd7;

    localparam logic [4:0] TEAM_LEN = 5'd4;

    // Keyword text, unused positions zero; keyword k maps to command code k+1.
    localparam logic [7:0] KW_TEXT [KW_COUNT][4] = '{
        '{8'h43, 8'h58, 8'h00, 8'h00},   // CX
        '{8'h53, 8'h49, 8'h4D, 8'h50},   // SIMP
        '{8'h53, 8'h49, 8'h4D, 8'h00},   // SIM
        '{8'h49, 8'h4D, 8'h55, 8'h00},   // IMU
        '{8'h43, 8'h41, 8'h4C, 8'h00},   // CAL
        '{8'h53, 8'h54, 8'h00, 8'h00},   // ST
        '{8'h43, 8'h52, 8'h00, 8'h00},   // CR
        '{8'h42, 8'h43, 8'h4E, 8'h00},   // BCN
        '{8'h47, 8'h42, 8'h00, 8'h00},   // GB
        '{8'h48, 8'h53, 8'h00, 8'h00},   // HS
        '{8'h43, 8'h41, 8'h4D, 8'h00}    // CAM
    };

    localparam logic [4:0] KW_LEN [KW_COUNT] = '{
        5'd2, 5'd4, 5'd3, 5'd3, 5'd3, 5'd2, 5'd2, 5'd3, 5'd2, 5'd2, 5'd3
    };

    typedef struct packed {
        logic                in_line;
        logic [4:0]          line_length;
        logic [2:0]          field_index;
        logic [4:0]          field_char_pos;
        logic [KW_COUNT-1:0] keyword_alive;
        logic                team_alive;
        logic                overflowed;
    } scl_state_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] command_code;
        logic       team_ok;
        logic       line_overflow;
    } scl_result_t;

endpackage

@@ sv/serial_command_line_recognizer.sv @@
// Decode: a byte accepted at a rising edge is held in the input register and decoded there;
//   the result of a closing carriage return is loaded into the result register when that
//   byte advances, and from there it sits on m_tdata.
// Throughput: one byte per cycle; only a closing carriage return waits, and only while
//   an earlier result is still held untaken on the result side.
// Reset: aresetn low at a rising edge clears the line state and both handshake stages
//   and loads team_code with "2032".
module serial_command_line_recognizer
    import scl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [3:0] command_code, [4] team_ok, [5] line_overflow

    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata    // team_code, first character in [31:24]
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    scl_state_t  st_reg;
    scl_state_t  st_next;
    scl_result_t res;
    logic        out_valid_reg;
    logic [3:0]  out_code_reg;
    logic        out_tok_reg;
    logic        out_ovf_reg;
    logic [31:0] team_code_reg;
    logic        advance;

    // Advance the held byte when it gives no result, or when the result register is
    // free or is being drained in this same cycle; only a closing byte ever waits on
    // the output side.
    assign advance  = in_valid_reg && (!res.valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    scl_core u_core (
        .rx_byte   (in_byte_reg),
        .team_code (team_code_reg),
        .st        (st_reg),
        .st_next   (st_next),
        .res       (res)
    );

    // Team code register: load on cfg_we; the writer must issue it only while no
    // transaction is in flight; the register itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            team_code_reg <= TEAM_CODE_RESET;
        end else if (cfg_we) begin
            team_code_reg <= cfg_wdata;
        end
    end

    // Input register: hold the byte of the last transaction until it is decoded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Line state: advance by one byte per decode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Result register: drop the held result once taken, load a new one on a close.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_code_reg <= res.command_code;
            out_tok_reg  <= res.team_ok;
            out_ovf_reg  <= res.line_overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_ovf_reg, out_tok_reg, out_code_reg};

endmodule

@@ sv/scl_core.sv @@
module scl_core
    import scl_pkg::*;
(
    input  logic [7:0]  rx_byte,
    input  logic [31:0] team_code,
    input  scl_state_t  st,
    output scl_state_t  st_next,
    output scl_result_t res
);

    logic [KW_COUNT-1:0] kw_closed;
    logic [KW_COUNT-1:0] kw_char_ok;
    logic                team_closed;
    logic                team_char_ok;
    logic [7:0]          team_char;
    logic                tok;
    logic [3:0]          first_code;

    // Team character at the current position, first character in the top byte.
    always_comb begin
        case (st.field_char_pos[1:0])
            2'd0:    team_char = team_code[31:24];
            2'd1:    team_char = team_code[23:16];
            2'd2:    team_char = team_code[15:8];
            default: team_char = team_code[7:0];
        endcase
    end

    assign team_char_ok = (st.field_char_pos < TEAM_LEN) && (team_char == rx_byte);

    // Field close: keep only exact-length candidates.
    always_comb begin
        team_closed = st.team_alive;
        if (st.field_index == FIELD_TEAM && st.field_char_pos != TEAM_LEN) begin
            team_closed = 1'b0;
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_closed[k] = st.keyword_alive[k];
            if (st.field_index == FIELD_KEYWORD && st.field_char_pos != KW_LEN[k]) begin
                kw_closed[k] = 1'b0;
            end
            kw_char_ok[k] = (st.field_char_pos < KW_LEN[k]) &&
                            (KW_TEXT[k][st.field_char_pos[1:0]] == rx_byte);
        end
    end

    // Lowest surviving keyword wins.
    always_comb begin
        first_code = CODE_NONE;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (kw_closed[k]) begin
                first_code = 4'(k + 1);
            end
        end
    end

    assign tok = (st.field_index >= FIELD_TEAM) && team_closed;

    always_comb begin
        st_next = st;
        res     = '0;
        if (!st.in_line) begin
            if (rx_byte == CHAR_OPEN) begin
                st_next.in_line        = 1'b1;
                st_next.line_length    = 5'd1;
                st_next.field_index    = 3'd0;
                st_next.field_char_pos = 5'd1;
                st_next.keyword_alive  = '1;
                st_next.team_alive     = 1'b1;
                st_next.overflowed     = 1'b0;
            end
        end else if (rx_byte == CHAR_CR) begin
            res.valid         = 1'b1;
            res.line_overflow = st.overflowed;
            if (!st.overflowed) begin
                res.team_ok = tok;
                if (tok && st.field_index >= FIELD_KEYWORD) begin
                    res.command_code = first_code;
                end
            end
            st_next = '0;
        end else if (!st.overflowed) begin
            if (st.line_length >= LINE_MAX) begin
                st_next.overflowed = 1'b1;
            end else begin
                st_next.line_length = st.line_length + 5'd1;
                if (rx_byte == CHAR_COMMA) begin
                    st_next.team_alive     = team_closed;
                    st_next.keyword_alive  = kw_closed;
                    st_next.field_char_pos = 5'd0;
                    if (st.field_index < FIELD_LAST) begin
                        st_next.field_index = st.field_index + 3'd1;
                    end
                end else begin
                    if (st.field_index == FIELD_TEAM) begin
                        st_next.team_alive = st.team_alive & team_char_ok;
                    end else if (st.field_index == FIELD_KEYWORD) begin
                        st_next.keyword_alive = st.keyword_alive & kw_char_ok;
                    end
                    if (st.field_char_pos < FIELD_MAX) begin
                        st_next.field_char_pos = st.field_char_pos + 5'd1;
                    end
                end
            end
        end
    end

endmodule
